// ===== sv/scs_pkg.sv =====
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and codes for the sparse chunked cell store.
// ----------------------------------------------------------------------------
package scs_pkg;

  // Action codes
  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_LOAD   = 3'd1;
  localparam logic [2:0] ACT_REMOVE = 3'd2;
  localparam logic [2:0] ACT_SET    = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;
  localparam logic [2:0] ACT_QUERY  = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Register indexes (word address)
  localparam logic [1:0] REG_CHUNK_W = 2'd0;
  localparam logic [1:0] REG_CHUNK_H = 2'd1;
  localparam logic [1:0] REG_LAYERS  = 2'd2;

  // Width of the local cell index before reduction (max 255)
  localparam int unsigned LOC_W = 9;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_FIX, S_RED, S_SRD, S_SCMP, S_DEC, S_ALLOC, S_CLR,
    S_CWR, S_CRD, S_CCAP, S_GRD, S_GWR, S_DONE
  } scs_state_e;

  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       div_fix;
    logic       red_step;
    logic       srd;
    logic       scmp;
    logic       alloc;
    logic       clr;
    logic       remove;
    logic       cwr;
    logic       crd;
    logic       ccap;
    logic       grd;
    logic       gwr;
    logic       out_load;
    logic [1:0] code;
    logic       present;
  } scs_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       last;
    logic       cidx_ok;
    logic       val_bad;
    logic       div_last;
    logic       red_done;
    logic       srch_last;
    logic       hit;
    logic       free;
    logic       clr_last;
  } scs_sts_t;

endpackage

// ===== sv/scs_cfg.sv =====
// ----------------------------------------------------------------------------
// scs_cfg
// Configuration registers behind the APB-style port, with effective sizes.
// ----------------------------------------------------------------------------
module scs_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [4:0]  width_o,
  output logic [4:0]  height_o,
  output logic [8:0]  layers_o
);

  logic [4:0] cw_q;
  logic [4:0] ch_q;
  logic [8:0] lc_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Write a register on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q <= 5'd16;
      ch_q <= 5'd16;
      lc_q <= 9'd256;
    end else if (wr_en) begin
      case (paddr[3:2])
        scs_pkg::REG_CHUNK_W: cw_q <= pwdata[4:0];
        scs_pkg::REG_CHUNK_H: ch_q <= pwdata[4:0];
        scs_pkg::REG_LAYERS:  lc_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[3:2])
      scs_pkg::REG_CHUNK_W: prdata = {27'd0, cw_q};
      scs_pkg::REG_CHUNK_H: prdata = {27'd0, ch_q};
      scs_pkg::REG_LAYERS:  prdata = {23'd0, lc_q};
      default:              prdata = 32'd0;
    endcase
  end

  // Clamp chunk width and height to 1..16; the layer count passes through
  always_comb begin
    width_o  = (cw_q == 5'd0) ? 5'd1 : ((cw_q > 5'd16) ? 5'd16 : cw_q);
    height_o = (ch_q == 5'd0) ? 5'd1 : ((ch_q > 5'd16) ? 5'd16 : ch_q);
    layers_o = lc_q;
  end

endmodule

// ===== sv/scs_ctrl.sv =====
// ----------------------------------------------------------------------------
// scs_ctrl
// Sequencer: division, index reduction, slot search, allocation or removal, cell
// access, generation update and result hand-off.
// ----------------------------------------------------------------------------
module scs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  scs_pkg::scs_sts_t  sts_i,
  output scs_pkg::scs_cmd_t  cmd_o
);

  scs_pkg::scs_state_e state_q, state_d;
  logic [1:0] code_q, code_d;
  logic       pres_q, pres_d;
  logic       out_valid_q;
  logic       accept;
  logic       wr_cell;
  logic       can_load;

  assign in_stall_o  = (state_q != scs_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i & (state_q == scs_pkg::S_IDLE);
  assign can_load    = !(out_valid_q && out_stall_i);
  assign wr_cell     = ((sts_i.action == scs_pkg::ACT_LOAD) && sts_i.cidx_ok) ||
                       (sts_i.action == scs_pkg::ACT_SET);

  // Next state
  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    pres_d  = pres_q;
    case (state_q)
      scs_pkg::S_IDLE: begin
        if (accept) begin
          code_d = scs_pkg::ST_OK;
          pres_d = 1'b0;
        end
        if (accept) begin
          state_d = (sts_i.action == scs_pkg::ACT_SET || sts_i.action == scs_pkg::ACT_READ)
                    ? scs_pkg::S_DIV : scs_pkg::S_RED;
        end
      end
      scs_pkg::S_DIV:  if (sts_i.div_last) state_d = scs_pkg::S_FIX;
      scs_pkg::S_FIX:  state_d = scs_pkg::S_RED;
      scs_pkg::S_RED:  if (sts_i.red_done) state_d = scs_pkg::S_SRD;
      scs_pkg::S_SRD:  state_d = scs_pkg::S_SCMP;
      scs_pkg::S_SCMP: state_d = sts_i.srch_last ? scs_pkg::S_DEC : scs_pkg::S_SRD;
      scs_pkg::S_DEC: begin
        state_d = scs_pkg::S_DONE;
        case (sts_i.action)
          scs_pkg::ACT_ADD, scs_pkg::ACT_LOAD, scs_pkg::ACT_SET: begin
            if (sts_i.action == scs_pkg::ACT_SET && sts_i.val_bad) begin
              code_d = scs_pkg::ST_RANGE;
              if (sts_i.hit) begin
                pres_d  = 1'b1;
                state_d = scs_pkg::S_GRD;
              end
            end else if (sts_i.hit) begin
              pres_d  = 1'b1;
              state_d = wr_cell ? scs_pkg::S_CWR : scs_pkg::S_GRD;
            end else if (sts_i.free) begin
              pres_d  = 1'b1;
              state_d = scs_pkg::S_ALLOC;
            end else begin
              code_d = scs_pkg::ST_FULL;
            end
          end
          scs_pkg::ACT_READ: begin
            if (sts_i.hit) begin
              pres_d  = 1'b1;
              state_d = scs_pkg::S_CRD;
            end
          end
          scs_pkg::ACT_QUERY: begin
            if (sts_i.hit) begin
              pres_d  = 1'b1;
              state_d = scs_pkg::S_GRD;
            end
          end
          default: state_d = scs_pkg::S_DONE;
        endcase
      end
      scs_pkg::S_ALLOC: state_d = scs_pkg::S_CLR;
      scs_pkg::S_CLR: begin
        if (sts_i.clr_last) state_d = wr_cell ? scs_pkg::S_CWR : scs_pkg::S_GRD;
      end
      scs_pkg::S_CWR:  state_d = scs_pkg::S_GRD;
      scs_pkg::S_CRD:  state_d = scs_pkg::S_CCAP;
      scs_pkg::S_CCAP: state_d = scs_pkg::S_GRD;
      scs_pkg::S_GRD:  state_d = scs_pkg::S_GWR;
      scs_pkg::S_GWR:  state_d = scs_pkg::S_DONE;
      scs_pkg::S_DONE: if (can_load) state_d = scs_pkg::S_IDLE;
      default:         state_d = scs_pkg::S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.code     = code_q;
    cmd_o.present  = pres_q;
    case (state_q)
      scs_pkg::S_IDLE:  cmd_o.load     = accept;
      scs_pkg::S_DIV:   cmd_o.div_step = 1'b1;
      scs_pkg::S_FIX:   cmd_o.div_fix  = 1'b1;
      scs_pkg::S_RED:   cmd_o.red_step = !sts_i.red_done;
      scs_pkg::S_SRD:   cmd_o.srd      = 1'b1;
      scs_pkg::S_SCMP:  cmd_o.scmp     = 1'b1;
      scs_pkg::S_DEC:   cmd_o.remove   = (sts_i.action == scs_pkg::ACT_REMOVE) && sts_i.hit;
      scs_pkg::S_ALLOC: cmd_o.alloc    = 1'b1;
      scs_pkg::S_CLR:   cmd_o.clr      = 1'b1;
      scs_pkg::S_CWR:   cmd_o.cwr      = 1'b1;
      scs_pkg::S_CRD:   cmd_o.crd      = 1'b1;
      scs_pkg::S_CCAP:  cmd_o.ccap     = 1'b1;
      scs_pkg::S_GRD:   cmd_o.grd      = 1'b1;
      scs_pkg::S_GWR:   cmd_o.gwr      = 1'b1;
      scs_pkg::S_DONE:  cmd_o.out_load = can_load;
      default: ;
    endcase
  end

  // State and result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scs_pkg::S_IDLE;
      code_q  <= scs_pkg::ST_OK;
      pres_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
      pres_q  <= pres_d;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_o.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

// ===== sv/scs_dp.sv =====
// ----------------------------------------------------------------------------
// scs_dp
// Datapath: floor dividers, index reduction, slot tables, cell memory and
// result register.
// ----------------------------------------------------------------------------
module scs_dp #(
  parameter int unsigned CHUNK_SLOTS     = 16,
  parameter int unsigned MAX_CHUNK_CELLS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scs_pkg::scs_cmd_t  cmd_i,
  output scs_pkg::scs_sts_t  sts_o,
  input  logic [2:0]         action_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic [7:0]         cell_index_i,
  input  logic [7:0]         cell_value_i,
  input  logic               last_cell_i,
  input  logic [4:0]         width_i,
  input  logic [4:0]         height_i,
  input  logic [8:0]         layers_i,
  output logic [1:0]         status_o,
  output logic [7:0]         read_value_o,
  output logic               chunk_present_o,
  output logic [31:0]        generation_o
);

  localparam int unsigned SW    = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;
  localparam int unsigned CW    = (MAX_CHUNK_CELLS > 1) ? $clog2(MAX_CHUNK_CELLS) : 1;
  localparam int unsigned DEPTH = CHUNK_SLOTS * MAX_CHUNK_CELLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW    = scs_pkg::LOC_W;
  localparam logic [12:0]   MAX13  = 13'(MAX_CHUNK_CELLS);
  localparam logic [AW-1:0] MAXA   = AW'(MAX_CHUNK_CELLS);
  localparam logic [SW-1:0] LAST_S = SW'(CHUNK_SLOTS - 1);
  localparam logic [CW-1:0] LAST_C = CW'(MAX_CHUNK_CELLS - 1);

  // Item registers
  logic [2:0]    act_q;
  logic          last_q, cidx_ok_q, val_bad_q;
  logic [7:0]    val_q;
  logic [63:0]   key_q;
  logic [LW-1:0] loc_q;
  logic [9:0]    wh;

  // Divider lanes
  logic          xneg_q, yneg_q;
  logic [31:0]   xq_q, yq_q;
  logic [4:0]    rx_q, ry_q;
  logic [4:0]    div_cnt_q;
  logic [5:0]    tx, ty;
  logic          gx, gy;
  logic [31:0]   qx, qy;
  logic [4:0]    lx, ly;

  // Search and slot state
  logic [SW-1:0] idx_q, slot_q, free_slot_q;
  logic          hit_q, free_q, new_q;
  logic [CHUNK_SLOTS-1:0] valid_q;
  logic [63:0]   key_mem [CHUNK_SLOTS];
  logic [63:0]   key_rd_q;
  logic [31:0]   gen_mem [CHUNK_SLOTS];
  logic [31:0]   gen_rd_q, gen_q, gen_new;
  logic          gen_inc;

  // Cell memory
  logic [7:0]    cell_mem [DEPTH];
  logic [7:0]    cell_rd_q, rv_q;
  logic [CW-1:0] clr_cnt_q, cloc;
  logic [AW-1:0] cell_addr;

  // Result register
  logic [1:0]    status_q;
  logic [7:0]    rvo_q;
  logic          pres_q;
  logic [31:0]   geno_q;

  assign wh = 10'(width_i) * 10'(height_i);

  // Restoring divide step, one quotient bit per lane
  assign tx = {rx_q, xq_q[31]};
  assign ty = {ry_q, yq_q[31]};
  assign gx = (tx >= {1'b0, width_i});
  assign gy = (ty >= {1'b0, height_i});

  // Floor correction for negative dividends
  always_comb begin
    qx = xq_q;
    lx = rx_q;
    if (xneg_q) begin
      qx = (rx_q == 5'd0) ? (32'd0 - xq_q) : ~xq_q;
      lx = (rx_q == 5'd0) ? 5'd0 : (width_i - rx_q);
    end
    qy = yq_q;
    ly = ry_q;
    if (yneg_q) begin
      qy = (ry_q == 5'd0) ? (32'd0 - yq_q) : ~yq_q;
      ly = (ry_q == 5'd0) ? 5'd0 : (height_i - ry_q);
    end
  end

  // Capture the item and run division, reduction and fixup
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q     <= action_i;
      last_q    <= last_cell_i;
      val_q     <= cell_value_i;
      cidx_ok_q <= ({2'd0, cell_index_i} < wh);
      val_bad_q <= ({1'b0, cell_value_i} >= layers_i);
      key_q     <= {coord_y_i, coord_x_i};
      loc_q     <= LW'(cell_index_i);
      xneg_q    <= coord_x_i[31];
      yneg_q    <= coord_y_i[31];
      xq_q      <= coord_x_i[31] ? (32'd0 - coord_x_i) : coord_x_i;
      yq_q      <= coord_y_i[31] ? (32'd0 - coord_y_i) : coord_y_i;
      rx_q      <= 5'd0;
      ry_q      <= 5'd0;
      div_cnt_q <= 5'd0;
    end else if (cmd_i.div_step) begin
      rx_q      <= gx ? 5'(tx - {1'b0, width_i}) : tx[4:0];
      ry_q      <= gy ? 5'(ty - {1'b0, height_i}) : ty[4:0];
      xq_q      <= {xq_q[30:0], gx};
      yq_q      <= {yq_q[30:0], gy};
      div_cnt_q <= div_cnt_q + 5'd1;
    end else if (cmd_i.div_fix) begin
      key_q <= {qy, qx};
      loc_q <= LW'(10'(ly) * 10'(width_i) + 10'(lx));
    end else if (cmd_i.red_step) begin
      loc_q <= LW'(13'(loc_q) - MAX13);
    end
  end

  // Slot search: first matching valid slot, first free slot; then allocation and the clear count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      slot_q      <= '0;
      free_slot_q <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      new_q       <= 1'b0;
      clr_cnt_q   <= '0;
    end else if (cmd_i.load) begin
      idx_q  <= '0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      new_q  <= 1'b0;
    end else if (cmd_i.scmp) begin
      if (valid_q[idx_q] && key_rd_q == key_q && !hit_q) begin
        hit_q  <= 1'b1;
        slot_q <= idx_q;
      end
      if (!valid_q[idx_q] && !free_q) begin
        free_q      <= 1'b1;
        free_slot_q <= idx_q;
      end
      if (idx_q != LAST_S) idx_q <= idx_q + SW'(1);
    end else if (cmd_i.alloc) begin
      slot_q    <= free_slot_q;
      new_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (cmd_i.clr) begin
      clr_cnt_q <= clr_cnt_q + CW'(1);
    end
  end

  // Slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.alloc) begin
      valid_q[free_slot_q] <= 1'b1;
    end else if (cmd_i.remove) begin
      valid_q[slot_q] <= 1'b0;
    end
  end

  // Key table
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) key_mem[free_slot_q] <= key_q;
    if (cmd_i.srd) key_rd_q <= key_mem[idx_q];
  end

  // Generation table
  assign gen_inc = (act_q == scs_pkg::ACT_ADD) ||
                   ((act_q == scs_pkg::ACT_LOAD) && last_q) ||
                   ((act_q == scs_pkg::ACT_SET) && !val_bad_q);
  assign gen_new = (new_q ? 32'd0 : gen_rd_q) + {31'd0, gen_inc};

  always_ff @(posedge clk_i) begin
    if (cmd_i.gwr) gen_mem[slot_q] <= gen_new;
    if (cmd_i.grd) gen_rd_q <= gen_mem[slot_q];
  end

  // Cell memory: clear sweep, single write, registered read
  assign cloc      = CW'(loc_q);
  assign cell_addr = AW'(slot_q) * MAXA + (cmd_i.clr ? AW'(clr_cnt_q) : AW'(cloc));

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      cell_mem[cell_addr] <= 8'd0;
    end else if (cmd_i.cwr) begin
      cell_mem[cell_addr] <= val_q;
    end
    if (cmd_i.crd) cell_rd_q <= cell_mem[cell_addr];
  end

  // Per-item read value and generation
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rv_q  <= 8'd0;
      gen_q <= 32'd0;
    end else begin
      if (cmd_i.ccap) rv_q <= cell_rd_q;
      if (cmd_i.gwr) gen_q <= gen_new;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q <= cmd_i.code;
      rvo_q    <= rv_q;
      pres_q   <= cmd_i.present;
      geno_q   <= cmd_i.present ? gen_q : 32'd0;
    end
  end

  assign status_o        = status_q;
  assign read_value_o    = rvo_q;
  assign chunk_present_o = pres_q;
  assign generation_o    = geno_q;

  // Status to the controller
  always_comb begin
    sts_o           = '0;
    sts_o.action    = act_q;
    sts_o.last      = last_q;
    sts_o.cidx_ok   = cidx_ok_q;
    sts_o.val_bad   = val_bad_q;
    sts_o.div_last  = (div_cnt_q == 5'd31);
    sts_o.red_done  = (13'(loc_q) < MAX13);
    sts_o.srch_last = (idx_q == LAST_S);
    sts_o.hit       = hit_q;
    sts_o.free      = free_q;
    sts_o.clr_last  = (clr_cnt_q == LAST_C);
    if (cmd_i.load) sts_o.action = action_i;
  end

endmodule

// ===== sv/sparse_chunked_cell_store_core.sv =====
// ----------------------------------------------------------------------------
// sparse_chunked_cell_store_core
// Sparse 2-D byte grid kept as chunks in allocated slots.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o  | action, coord_x/y, cell_index,
//          |           |                        | cell_value, last_cell
//  out     | output    | out_valid_o / out_stall_i| status, read_value,
//          |           |                        | chunk_present, generation
//  cfg     | input     | psel/penable/pwrite    | paddr, pwdata, prdata
//
// One transaction at a time. Every item runs the local-index reduction,
// a slot search and a decision; set/read cell first runs a serial floor
// divide (one bit a cycle), and an allocated slot gets a clear sweep of its
// cells. The slot search reads the key table one slot at a time.
// Reset clears slot valid bits; no clearing pass after reset.
// A stalled result holds in the output register; the next item completes
// only once it has been taken.
module sparse_chunked_cell_store_core #(
  parameter int unsigned CHUNK_SLOTS     = 16,
  parameter int unsigned MAX_CHUNK_CELLS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         action_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic [7:0]         cell_index_i,
  input  logic [7:0]         cell_value_i,
  input  logic               last_cell_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [7:0]         read_value_o,
  output logic               chunk_present_o,
  output logic [31:0]        generation_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  scs_pkg::scs_cmd_t cmd;
  scs_pkg::scs_sts_t sts;
  logic [4:0] width;
  logic [4:0] height;
  logic [8:0] layers;

  // Configuration registers
  scs_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .width_o  (width),
    .height_o (height),
    .layers_o (layers)
  );

  // Sequencer
  scs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath
  scs_dp #(
    .CHUNK_SLOTS     (CHUNK_SLOTS),
    .MAX_CHUNK_CELLS (MAX_CHUNK_CELLS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .action_i        (action_i),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .cell_index_i    (cell_index_i),
    .cell_value_i    (cell_value_i),
    .last_cell_i     (last_cell_i),
    .width_i         (width),
    .height_i        (height),
    .layers_i        (layers),
    .status_o        (status_o),
    .read_value_o    (read_value_o),
    .chunk_present_o (chunk_present_o),
    .generation_o    (generation_o)
  );

endmodule

// ===== sv/scs_chk.sv =====
// ----------------------------------------------------------------------------
// scs_chk
// Port-level checks on the cell store, bound to the top level.
// ----------------------------------------------------------------------------
module scs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [7:0]  read_value_o,
  input logic        chunk_present_o,
  input logic [31:0] generation_o
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(generation_o) && $stable(read_value_o))
    else $error("stalled result changed");

  // An accepted transaction blocks the input on the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // A full table reports no chunk
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == scs_pkg::ST_FULL |-> !chunk_present_o && generation_o == 32'd0)
    else $error("full status with chunk present");

  // Absent chunk gives zero generation and read value
  a_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !chunk_present_o |-> generation_o == 32'd0 && read_value_o == 8'd0)
    else $error("absent chunk with nonzero fields");

  // Status code is never the unused one
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("bad status code");

endmodule

bind sparse_chunked_cell_store_core scs_chk u_scs_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .read_value_o    (read_value_o),
  .chunk_present_o (chunk_present_o),
  .generation_o    (generation_o)
);
